// ===== src/sthr_pkg.sv =====
// ----------------------------------------------------------------------------
// sthr_pkg
// Shared codes and controller/datapath interface types for the sequence
// tagged history ring.
// ----------------------------------------------------------------------------
package sthr_pkg;

  // Width of a stored sequence tag (a sequence is never negative once stored).
  localparam int TAG_W = 31;

  // Operation codes.
  localparam logic [1:0] OP_SAVE   = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_EXISTS     = 2'd1;
  localparam logic [1:0] STATUS_NO_ENTRIES = 2'd2;
  localparam logic [1:0] STATUS_INVALID    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;      // latch the incoming transaction
    logic       wr_zero;     // store the tag-0 copy into slot 0
    logic       wr_req;      // store the requested sequence in the next slot, or slot 0 in an empty ring
    logic       clear;       // empty the ring
    logic       walk_init;   // point the walk at the newest slot
    logic       walk_step;   // move the walk one slot older
    logic       rd_en;       // read the slot under the walk pointer
    logic       set_res;     // capture the result descriptor below
    logic [1:0] res_status;
    logic       res_fb;
    logic       res_mem;     // result carries the slot last read
    logic       out_load;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       req_neg;
    logic       req_all_ones;
    logic       req_zero;
    logic       empty;
    logic       not_newer;
    logic       hit;
    logic       walk_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== src/sthr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sthr_ctrl
// Controller state machine: decodes each transaction and sequences ring
// writes, the slot walk and the hand-off to the output register.
// ----------------------------------------------------------------------------
module sthr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sthr_pkg::sts_t sts,
  output sthr_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SAVE2  = 3'd2;
  localparam logic [2:0] S_WRD    = 3'd3;
  localparam logic [2:0] S_WCMP   = 3'd4;
  localparam logic [2:0] S_NRD    = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_res = 1'b1;
        state_next  = S_RESP;
        unique case (sts.op)
          sthr_pkg::OP_SAVE: begin
            priority if (sts.req_neg) begin
              cmd.res_status = sthr_pkg::STATUS_INVALID;
            end else if (!sts.empty && sts.not_newer) begin
              cmd.res_status = sthr_pkg::STATUS_EXISTS;
            end else if (sts.empty && !sts.req_zero) begin
              cmd.wr_zero = 1'b1;
              cmd.set_res = 1'b0;
              state_next  = S_SAVE2;
            end else begin
              cmd.wr_req     = 1'b1;
              cmd.res_status = sthr_pkg::STATUS_OK;
            end
          end
          sthr_pkg::OP_LOOKUP: begin
            priority if (sts.empty) begin
              cmd.res_status = sthr_pkg::STATUS_NO_ENTRIES;
            end else if (sts.req_all_ones) begin
              cmd.walk_init  = 1'b1;
              cmd.res_status = sthr_pkg::STATUS_OK;
              cmd.res_mem    = 1'b1;
              state_next     = S_NRD;
            end else begin
              cmd.walk_init = 1'b1;
              cmd.set_res   = 1'b0;
              state_next    = S_WRD;
            end
          end
          sthr_pkg::OP_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.res_status = sthr_pkg::STATUS_OK;
          end
          default: begin
            cmd.res_status = sthr_pkg::STATUS_OK;
          end
        endcase
      end
      S_SAVE2: begin
        cmd.wr_req     = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = sthr_pkg::STATUS_OK;
        state_next     = S_RESP;
      end
      S_WRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_WCMP;
      end
      S_WCMP: begin
        priority if (sts.hit) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = sthr_pkg::STATUS_OK;
          cmd.res_mem    = 1'b1;
          state_next     = S_RESP;
        end else if (sts.walk_last) begin
          // Nothing old enough: fall back to the newest slot.
          cmd.walk_init  = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = sthr_pkg::STATUS_OK;
          cmd.res_mem    = 1'b1;
          cmd.res_fb     = 1'b1;
          state_next     = S_NRD;
        end else begin
          cmd.walk_step = 1'b1;
          state_next    = S_WRD;
        end
      end
      S_NRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/sthr_dpath.sv =====
// ----------------------------------------------------------------------------
// sthr_dpath
// Datapath: ring memory, fill count, newest pointer and tag, walk pointer,
// transaction registers and the output register.
// ----------------------------------------------------------------------------
module sthr_dpath #(
  parameter int DEPTH         = 8,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         operation,
  input  logic signed [31:0] sequence_req,
  input  logic [31:0]        payload,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [31:0]        found_payload,
  output logic signed [31:0] found_sequence,
  output logic               used_fallback,
  input  sthr_pkg::cmd_t     cmd,
  output sthr_pkg::sts_t     sts
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
  localparam int TW = sthr_pkg::TAG_W;
  localparam int EW = TW + SW;
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(DEPTH);

  // Latched transaction.
  logic [1:0]    op_q;
  logic [31:0]   req_q;
  logic [SW-1:0] pay_q;

  // Ring state.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data;
  logic [IW-1:0] newest;
  logic [TW-1:0] newest_tag;
  logic [CW-1:0] count;
  logic [IW-1:0] walk_addr;
  logic [IW-1:0] walk_cnt;

  // Pending result descriptor.
  logic [1:0] res_status;
  logic       res_fb;
  logic       res_mem;

  logic [IW-1:0] next_slot;
  logic [IW-1:0] prev_walk;
  logic [IW-1:0] wr_addr;
  logic [TW-1:0] wr_tag;
  logic          wr_en;
  logic [TW-1:0] rd_tag;
  logic [SW-1:0] rd_pay;

  assign next_slot = (newest == LAST_SLOT) ? '0 : newest + IW'(1);
  assign prev_walk = (walk_addr == '0) ? LAST_SLOT : walk_addr - IW'(1);
  assign wr_en     = cmd.wr_zero || cmd.wr_req;
  assign wr_addr   = (cmd.wr_zero || count == '0) ? '0 : next_slot;
  assign wr_tag    = cmd.wr_zero ? '0 : req_q[TW-1:0];
  assign rd_tag    = rd_data[EW-1:SW];
  assign rd_pay    = rd_data[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= operation;
      req_q <= sequence_req;
      pay_q <= payload[SW-1:0];
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_fb     <= cmd.res_fb;
      res_mem    <= cmd.res_mem;
    end
    if (wr_en) begin
      newest_tag <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tag, pay_q};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[walk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      newest <= '0;
      count  <= '0;
    end else if (wr_en) begin
      newest <= wr_addr;
      if (count != FULL) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_addr <= newest;
      walk_cnt  <= '0;
    end else if (cmd.walk_step) begin
      walk_addr <= prev_walk;
      walk_cnt  <= walk_cnt + IW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= res_status;
      used_fallback  <= res_fb;
      found_payload  <= res_mem ? 32'(rd_pay) : '0;
      found_sequence <= res_mem ? $signed({1'b0, rd_tag}) : -32'sd1;
    end
  end

  always_comb begin
    sts              = '0;
    sts.op           = op_q;
    sts.req_neg      = req_q[31];
    sts.req_all_ones = &req_q;
    sts.req_zero     = (req_q == '0);
    sts.empty        = (count == '0);
    sts.not_newer    = ({1'b0, newest_tag} >= req_q);
    sts.hit          = !req_q[31] && ({1'b0, rd_tag} <= req_q);
    sts.walk_last    = ((CW'(walk_cnt) + CW'(1)) == count);
    sts.out_free     = !out_valid || !out_stall;
  end

endmodule

// ===== src/sequence_tagged_history_ring_unit.sv =====
// ----------------------------------------------------------------------------
// sequence_tagged_history_ring_unit
// Ring of DEPTH frame-sequence-tagged parameter words with save, lookup by
// sequence and clear.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries one transaction: operation,
//   sequence_req and payload. The output channel (out_valid/out_stall) returns
//   exactly one result transaction per input transaction, in order.
//   The block works on one transaction at a time. A save is decoded and, if
//   it is taken, written before the result goes to the output register; the
//   first save into an empty ring also first stores the copy tagged 0. A
//   lookup of -1 reads the newest slot. Any other lookup walks the ring from
//   newest to oldest through the single read port of the slot memory, reading
//   and then comparing each filled slot: a hit ends the walk, and when no slot
//   is old enough it falls back to the newest slot. in_stall is high from
//   acceptance until the result has entered the output register.
//   While the receiver stalls, the finished result waits in the output
//   register and the block takes one more transaction, which it holds
//   until the output register frees up.
//   Reset empties the ring and drops any result in flight; slot contents are
//   not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module sequence_tagged_history_ring_unit #(
  parameter int DEPTH         = 8,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic signed [31:0] sequence_req,
  input  logic [31:0]        payload,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [31:0]        found_payload,
  output logic signed [31:0] found_sequence,
  output logic               used_fallback
);

  // Command and status bundles between the controller and the datapath.
  sthr_pkg::cmd_t cmd;
  sthr_pkg::sts_t sts;

  // The controller decides what happens in each cycle; it sees only the
  // condensed status of the latched transaction and of the ring.
  sthr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the slot memory, fill count, newest pointer, the walk
  // pointer and the output register.
  sthr_dpath #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .operation      (operation),
    .sequence_req   (sequence_req),
    .payload        (payload),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_payload  (found_payload),
    .found_sequence (found_sequence),
    .used_fallback  (used_fallback),
    .cmd            (cmd),
    .sts            (sts)
  );

`ifndef SYNTHESIS
  // A result only moves into the output register when that register is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded into an occupied output register");

  // The tag-0 copy is always followed by the write of the requested sequence.
  a_zero_then_req: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_zero |=> cmd.wr_req)
    else $error("tag-0 copy not followed by the requested save");

  // The input side reopens only after a result has been handed off.
  a_reopen_after_load: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> $past(cmd.out_load))
    else $error("input reopened without delivering a result");
`endif

endmodule

// ===== verif/tb_sequence_tagged_history_ring_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequence_tagged_history_ring_unit
// Self-checking bench for the sequence tagged history ring. A short table of
// hand-picked transactions hits the corner cases first: empty ring, negative
// saves, stale saves, the tag-0 copy, walks that stop at an empty slot,
// fall-back and clear. A long stream of random, mostly well-formed traffic follows.
// Results are checked against typed table answers or a behavioral ring copy.
// ----------------------------------------------------------------------------
module tb_sequence_tagged_history_ring_unit;

  localparam int DEPTH         = 8;
  localparam int PAYLOAD_WIDTH = 32;

  // The package stops at clear; code 3 is reserved and must leave the ring alone.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic signed [31:0] NO_TAG  = -32'sd1;
  localparam logic signed [31:0] TOP_SEQ = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_SEQ = 32'sh8000_0000;

  localparam int RANDOM_ITEMS = 1830;
  localparam int QUIET_FIRST  = 700;   // random items in [QUIET_FIRST, QUIET_LAST)
  localparam int QUIET_LAST   = 1000;  // run with neither side idling
  localparam int DRAIN_AT     = 1200;  // mid-run pause until the ring has answered all
  localparam int SETTLE       = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 400000;

  // One result transaction as the block presents it.
  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        word;
    logic signed [31:0] tag;
    logic               fallback;
  } ring_reply_t;

  // One row of the directed table. When typed is set, exp is the answer that
  // follows at a glance from the rules of the ring; otherwise the behavioral
  // ring decides.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] req;
    logic [31:0]        word;
    logic               typed;
    ring_reply_t        exp;
  } dir_row_t;

  localparam ring_reply_t R_QUIET   = '{sthr_pkg::STATUS_OK, 32'h0, NO_TAG, 1'b0};
  localparam ring_reply_t R_EMPTY   = '{sthr_pkg::STATUS_NO_ENTRIES, 32'h0, NO_TAG, 1'b0};
  localparam ring_reply_t R_INVALID = '{sthr_pkg::STATUS_INVALID, 32'h0, NO_TAG, 1'b0};
  localparam ring_reply_t R_EXISTS  = '{sthr_pkg::STATUS_EXISTS, 32'h0, NO_TAG, 1'b0};

  localparam int DIR_N = 24;

  // Directed table. The ring is empty at its start.
  dir_row_t dir_rows [0:DIR_N-1] = '{
    // Lookups on an empty ring, newest and by sequence.
    '{sthr_pkg::OP_LOOKUP, NO_TAG,      32'h0,         1'b1, R_EMPTY},
    '{sthr_pkg::OP_LOOKUP, 32'sd5,      32'h0,         1'b1, R_EMPTY},
    // Negative saves are rejected, the all-ones and the most negative pattern.
    '{sthr_pkg::OP_SAVE,   NO_TAG,      32'hDEAD_BEEF, 1'b1, R_INVALID},
    '{sthr_pkg::OP_SAVE,   MIN_SEQ,     32'hFFFF_FFFF, 1'b1, R_INVALID},
    // First nonzero save stores the tag-0 copy and then tag 10.
    '{sthr_pkg::OP_SAVE,   32'sd10,     32'hFFFF_FFFF, 1'b1, R_QUIET},
    // Equal and older sequences are stale.
    '{sthr_pkg::OP_SAVE,   32'sd10,     32'h0000_1234, 1'b1, R_EXISTS},
    '{sthr_pkg::OP_SAVE,   32'sd5,      32'h0000_5678, 1'b1, R_EXISTS},
    '{sthr_pkg::OP_LOOKUP, NO_TAG,      32'h0,         1'b1,
      '{sthr_pkg::STATUS_OK, 32'hFFFF_FFFF, 32'sd10, 1'b0}},
    // Walk passes tag 10 and lands on the tag-0 copy.
    '{sthr_pkg::OP_LOOKUP, 32'sd3,      32'h0,         1'b1,
      '{sthr_pkg::STATUS_OK, 32'hFFFF_FFFF, 32'sd0, 1'b0}},
    // A negative request other than -1 walks into the empty slot and falls back.
    '{sthr_pkg::OP_LOOKUP, -32'sd2,     32'h0,         1'b1,
      '{sthr_pkg::STATUS_OK, 32'hFFFF_FFFF, 32'sd10, 1'b1}},
    '{sthr_pkg::OP_LOOKUP, TOP_SEQ,     32'h0,         1'b0, R_QUIET},
    // Reserved code does nothing, even with a save-worthy sequence.
    '{OP_RESERVED,         TOP_SEQ,     32'hFFFF_FFFF, 1'b1, R_QUIET},
    '{sthr_pkg::OP_CLEAR,  32'sd0,      32'h0,         1'b1, R_QUIET},
    '{sthr_pkg::OP_LOOKUP, 32'sd7,      32'h0,         1'b1, R_EMPTY},
    // A first save of sequence 0 stores no extra copy.
    '{sthr_pkg::OP_SAVE,   32'sd0,      32'h0,         1'b1, R_QUIET},
    '{sthr_pkg::OP_LOOKUP, NO_TAG,      32'h0,         1'b0, R_QUIET},
    '{sthr_pkg::OP_SAVE,   TOP_SEQ,     32'hA5A5_A5A5, 1'b1, R_QUIET},
    '{sthr_pkg::OP_SAVE,   TOP_SEQ,     32'h0,         1'b1, R_EXISTS},
    '{sthr_pkg::OP_LOOKUP, TOP_SEQ - 1, 32'h0,         1'b0, R_QUIET},
    '{sthr_pkg::OP_LOOKUP, MIN_SEQ,     32'h0,         1'b0, R_QUIET},
    '{sthr_pkg::OP_CLEAR,  NO_TAG,      32'hFFFF_FFFF, 1'b1, R_QUIET},
    // Largest sequence into an empty ring, with its tag-0 copy.
    '{sthr_pkg::OP_SAVE,   TOP_SEQ,     32'h5A5A_5A5A, 1'b1, R_QUIET},
    '{sthr_pkg::OP_LOOKUP, 32'sd0,      32'h0,         1'b0, R_QUIET},
    '{sthr_pkg::OP_SAVE,   32'sd1,      32'h0,         1'b1, R_EXISTS}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         operation = sthr_pkg::OP_SAVE;
  logic signed [31:0] sequence_req = 32'sd0;
  logic [31:0]        payload = 32'h0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [31:0]        found_payload;
  logic signed [31:0] found_sequence;
  logic               used_fallback;

  // Results the ring still owes us, oldest first.
  ring_reply_t pending_replies[$];

  int errors = 0;
  int cycles = 0;
  int stall_hold = 0;
  // Set while both sides run flat out.
  logic quiet = 1'b0;

  // Behavioral copy of the ring.
  logic                       ring_live;
  int                         ring_head;
  logic                       slot_full [DEPTH];
  logic [sthr_pkg::TAG_W-1:0] slot_seq  [DEPTH];
  logic [31:0]                slot_word [DEPTH];

  sequence_tagged_history_ring_unit #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .sequence_req   (sequence_req),
    .payload        (payload),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_payload  (found_payload),
    .found_sequence (found_sequence),
    .used_fallback  (used_fallback)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs on either channel.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_sequence_tagged_history_ring_unit: done, errors");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    // Keep the log readable when something is badly broken.
    if (errors < 100) $display("[%0t ns] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic void empty_ring();
    ring_live = 1'b0;
    ring_head = 0;
    for (int i = 0; i < DEPTH; i++) slot_full[i] = 1'b0;
  endfunction

  // Advance the newest pointer, except into an empty ring, which restarts at slot 0.
  function automatic void push_slot(input logic [sthr_pkg::TAG_W-1:0] tag,
                                    input logic [31:0] word);
    if (ring_live) begin
      ring_head = (ring_head + 1) % DEPTH;
    end else begin
      ring_head = 0;
    end
    ring_live = 1'b1;
    slot_full[ring_head] = 1'b1;
    slot_seq[ring_head]  = tag;
    slot_word[ring_head] = word;
  endfunction

  // Apply one accepted transaction to the ring copy and return what the block
  // should answer.
  function automatic ring_reply_t step_history(input logic [1:0] op,
                                               input logic signed [31:0] req,
                                               input logic [31:0] word);
    ring_reply_t r;
    int idx;
    int pick;
    logic hit;
    r = R_QUIET;
    case (op)
      sthr_pkg::OP_SAVE: begin
        if (req < 0) begin
          r.status = sthr_pkg::STATUS_INVALID;
        end else if (ring_live && {1'b0, slot_seq[ring_head]} >= $unsigned(req)) begin
          r.status = sthr_pkg::STATUS_EXISTS;
        end else begin
          // The very first entry after empty gets a companion tagged 0 unless
          // it is itself sequence 0.
          if (!ring_live && req != 0) push_slot('0, word);
          push_slot(req[sthr_pkg::TAG_W-1:0], word);
        end
      end
      sthr_pkg::OP_LOOKUP: begin
        if (!ring_live) begin
          r.status = sthr_pkg::STATUS_NO_ENTRIES;
        end else begin
          pick = ring_head;
          if (req != NO_TAG) begin
            hit = 1'b0;
            // Newest to oldest; an empty slot ends the search. A negative
            // request can never be met by a stored tag.
            for (int i = 0; i < DEPTH && !hit; i++) begin
              idx = (ring_head + DEPTH - i) % DEPTH;
              if (!slot_full[idx]) break;
              if (!req[31] && {1'b0, slot_seq[idx]} <= $unsigned(req)) begin
                pick = idx;
                hit  = 1'b1;
              end
            end
            if (!hit) begin
              pick = ring_head;
              r.fallback = 1'b1;
            end
          end
          r.word = slot_word[pick];
          r.tag  = {1'b0, slot_seq[pick]};
        end
      end
      sthr_pkg::OP_CLEAR: empty_ring();
      default: ;
    endcase
    return r;
  endfunction

  // Random traffic is shaped around the ring's current newest tag, so most
  // saves land and most lookups search a populated ring.
  task automatic pick_random(output logic [1:0] op, output logic signed [31:0] req,
                             output logic [31:0] word);
    longint newest;
    longint cand;
    int roll;
    newest = ring_live ? longint'(slot_seq[ring_head]) : -64'sd1;
    roll   = $urandom_range(0, 99);
    word   = $urandom;
    op     = sthr_pkg::OP_LOOKUP;
    req    = $urandom;
    if (roll < 40) begin
      // Save of a newer sequence; mostly small steps, now and then a big jump.
      op = sthr_pkg::OP_SAVE;
      if (newest < 0) begin
        cand = ($urandom_range(0, 3) == 0) ? 64'sd0 : longint'($urandom_range(1, 40));
      end else if ($urandom_range(0, 19) == 0) begin
        cand = newest + longint'($urandom_range(1, 32'h3FFF_FFFF));
      end else begin
        cand = newest + longint'($urandom_range(1, 25));
      end
      // Out of sequence space: start over.
      if (cand > longint'(TOP_SEQ)) op = sthr_pkg::OP_CLEAR;
      req = cand[31:0];
    end else if (roll < 48) begin
      // Stale save, equal to or just below the newest tag.
      op   = sthr_pkg::OP_SAVE;
      cand = (newest < 0) ? longint'($urandom_range(0, 40))
                          : newest - longint'($urandom_range(0, 5));
      req  = cand[31:0];
    end else if (roll < 76) begin
      // Lookup in and just below the stored window.
      cand = (newest < 0) ? longint'($urandom_range(0, 50))
                          : newest - longint'($urandom_range(0, 80));
      req  = cand[31:0];
    end else if (roll < 81) begin
      req = NO_TAG;
    end else if (roll < 85) begin
      req = $urandom;
    end else if (roll < 88) begin
      op  = sthr_pkg::OP_SAVE;
      req = {1'b1, 31'($urandom)};
    end else if (roll < 90) begin
      op = OP_RESERVED;
    end else if (roll < 92) begin
      op = sthr_pkg::OP_CLEAR;
    end else begin
      // Lookup above the newest tag.
      cand = (newest < 0) ? longint'($urandom_range(0, 50))
                          : newest + longint'($urandom_range(1, 100));
      req  = (cand > longint'(TOP_SEQ)) ? TOP_SEQ : cand[31:0];
    end
  endtask

  // Present one transaction, wait for the handshake, then record what the ring
  // owes. Called and returns at a falling edge.
  task automatic send_item(input logic [1:0] op, input logic signed [31:0] req,
                           input logic [31:0] word, input logic typed,
                           input ring_reply_t given);
    ring_reply_t reply;
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    sequence_req <= req;
    payload      <= word;
    do @(posedge clk); while (in_stall);
    reply = step_history(op, req, word);
    pending_replies.push_back(typed ? given : reply);
    @(negedge clk);
  endtask

  // Hold the input channel idle until every owed result has come back.
  task automatic drain_ring();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  // The receiver stalls in short bursts, roughly one cycle in eight overall,
  // except during the quiet window.
  always @(negedge clk) begin
    if (rst || quiet) begin
      stall_hold <= 0;
      out_stall  <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 99) < 4) begin
      stall_hold <= $urandom_range(0, 5);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result that leaves the block is checked against the oldest owed one.
  always @(posedge clk) begin : check_results
    ring_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status=%0d seq=%0d", status,
                                found_sequence));
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (found_payload !== want.word)
          flag_mismatch($sformatf("found_payload %h, want %h", found_payload, want.word));
        if (found_sequence !== want.tag)
          flag_mismatch($sformatf("found_sequence %0d, want %0d", found_sequence,
                                  want.tag));
        if (used_fallback !== want.fallback)
          flag_mismatch($sformatf("used_fallback %b, want %b", used_fallback,
                                  want.fallback));
      end
    end
  end

  initial begin : stimulus
    logic [1:0]         op;
    logic signed [31:0] req;
    logic [31:0]        word;
    empty_ring();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      send_item(dir_rows[i].op, dir_rows[i].req, dir_rows[i].word, dir_rows[i].typed,
                dir_rows[i].exp);
    end
    drain_ring();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet <= (n >= QUIET_FIRST && n < QUIET_LAST);
      if (n == DRAIN_AT) drain_ring();
      pick_random(op, req, word);
      send_item(op, req, word, 1'b0, R_QUIET);
    end

    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    // Catch any stray result the block might still push out.
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb_sequence_tagged_history_ring_unit: done, clean");
    end else begin
      $display("tb_sequence_tagged_history_ring_unit: done, errors");
    end
    $finish;
  end

endmodule
